@@ rtl/tllc_pkg.sv @@
`timescale 1ns / 1ps
package tllc_pkg;

  localparam int I_SETS_DEF  = 64;
  localparam int I_WAYS_DEF  = 4;
  localparam int D_SETS_DEF  = 64;
  localparam int D_WAYS_DEF  = 4;
  localparam int L2_SETS_DEF = 256;
  localparam int L2_WAYS_DEF = 8;

  localparam logic [2:0] REG_I_HIT  = 3'd0;
  localparam logic [2:0] REG_D_HIT  = 3'd1;
  localparam logic [2:0] REG_L2_HIT = 3'd2;
  localparam logic [2:0] REG_MEM    = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;
  localparam logic [2:0] REG_I_EN   = 3'd5;
  localparam logic [2:0] REG_D_EN   = 3'd6;
  localparam logic [2:0] REG_L2_EN  = 3'd7;

  localparam logic MODE_INSTR = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [10:0] access_time;
    logic        l1_hit;
    logic        l2_looked_up;
    logic        l2_hit;
  } rsp_t;

  typedef struct packed {
    logic [7:0] i_hit_time;
    logic [7:0] d_hit_time;
    logic [7:0] l2_hit_time;
    logic [9:0] mem_latency;
    logic [3:0] offset_bits;
    logic       i_enable;
    logic       d_enable;
    logic       l2_enable;
  } cfg_t;

  // controller -> cache level
  typedef struct packed {
    logic rd;   // read set
    logic upd;  // write back updated set
  } lvl_cmd_t;

  // cache level -> controller
  typedef struct packed {
    logic hit;
    logic ready;  // clearing pass finished
  } lvl_sts_t;

endpackage

@@ rtl/tllc_level.sv @@
`timescale 1ns / 1ps
// One set-associative tag store with true LRU. Read a set, then write it back.
// Valid bits live in the memory rows; after reset the rows are cleared one set
// per cycle (NS rows: SETS rounded down to a power of two).
module tllc_level import tllc_pkg::*; #(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  lvl_cmd_t    cmd,
  input  logic [31:0] addr,
  input  logic [3:0]  offset_bits,
  output lvl_sts_t    sts
);
  localparam int IB  = $clog2(SETS + 1) - 1;     // floor log2
  localparam int IW  = (IB > 0) ? IB : 1;
  localparam int NS  = 1 << IB;
  localparam int TW  = 32 - IB;
  localparam int RW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WW  = $clog2(WAYS + 1);
  localparam int EW  = 1 + TW + RW;              // valid, tag, rank
  localparam int ROW = WAYS * EW;

  logic [ROW-1:0] mem [NS];
  logic [ROW-1:0] row;
  logic [WAYS-1:0] vrow;
  logic [IW-1:0]  clr;
  logic           clearing;

  logic [IW-1:0] set;
  logic [TW-1:0] tag;
  logic [63:0]   sh;

  assign sh  = {32'd0, addr} >> offset_bits;
  assign set = (IB > 0) ? sh[IW-1:0] : '0;
  assign tag = sh[IB +: TW];

  logic [TW-1:0] rtag [WAYS];
  logic [RW-1:0] rrank [WAYS];
  logic [ROW-1:0] wrow;
  logic [WW-1:0] way;
  logic          hit;
  logic [RW-1:0] old;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      vrow[w]  = row[w*EW + RW + TW];
      rtag[w]  = row[w*EW + RW +: TW];
      rrank[w] = row[w*EW +: RW];
    end
  end

  always_comb begin
    logic found;
    hit = 1'b0;
    way = WW'(WAYS);
    found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vrow[w] && rtag[w] == tag) begin
        hit = 1'b1;
        way = WW'(w);
      end
    end
    if (!hit) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !vrow[w]) begin
          found = 1'b1;
          way = WW'(w);
        end
      end
      if (!found) begin
        way = '0;
        for (int w = 1; w < WAYS; w++)
          if (rrank[w] > rrank[way[RW-1:0]]) way = WW'(w);
      end
    end
    old = vrow[way[RW-1:0]] ? rrank[way[RW-1:0]] : RW'(WAYS - 1);
    for (int w = 0; w < WAYS; w++) begin
      wrow[w*EW + RW + TW] = vrow[w];
      wrow[w*EW + RW +: TW] = rtag[w];
      wrow[w*EW +: RW] = rrank[w];
      if (WW'(w) == way) begin
        wrow[w*EW + RW + TW] = 1'b1;
        wrow[w*EW + RW +: TW] = tag;
        wrow[w*EW +: RW] = '0;
      end else if (vrow[w] && rrank[w] < old) begin
        wrow[w*EW +: RW] = rrank[w] + 1'b1;
      end
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr <= clr + 1'b1;
      if (clr == IW'(NS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) row <= mem[set];
    if (!rst && clearing) mem[clr] <= '0;
    else if (cmd.upd) mem[set] <= wrow;
  end

  assign sts = '{hit: hit, ready: !clearing};
endmodule

@@ rtl/tllc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: L1 read, L1 update, L2 read, L2 update, result; the L2 steps are skipped on an L1 hit or with L2 disabled.
module tllc_ctrl import tllc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  req_t     req,
  input  cfg_t     cfg,
  input  lvl_sts_t i_sts,
  input  lvl_sts_t d_sts,
  input  lvl_sts_t l2_sts,
  output lvl_cmd_t i_cmd,
  output lvl_cmd_t d_cmd,
  output lvl_cmd_t l2_cmd,
  output logic     busy,
  output req_t     cur,
  output logic     done,
  output rsp_t     rsp
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_L1   = 3'd1;
  localparam logic [2:0] S_L2R  = 3'd2;
  localparam logic [2:0] S_L2   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic       l1_on, l1h;
  logic [7:0] l1_time;
  logic       l1_hit, l2_hit, l2_looked;
  logic       take;

  assign l1_on   = (cur.mode == MODE_DATA) ? cfg.d_enable : cfg.i_enable;
  assign l1_time = (cur.mode == MODE_DATA) ? cfg.d_hit_time : cfg.i_hit_time;
  assign l1h     = (cur.mode == MODE_DATA) ? d_sts.hit : i_sts.hit;
  // stay busy until every tag store has finished its clearing pass
  assign busy    = state != S_IDLE || !(i_sts.ready && d_sts.ready && l2_sts.ready);
  assign take    = start && !busy;

  always_comb begin
    state_next = state;
    i_cmd = '0; d_cmd = '0; l2_cmd = '0;
    case (state)
      S_IDLE: if (take) state_next = S_L1;
      S_L1: begin
        if (l1_on) begin
          i_cmd.upd = cur.mode == MODE_INSTR;
          d_cmd.upd = cur.mode == MODE_DATA;
        end
        state_next = (l1_on && l1h) || !cfg.l2_enable ? S_OUT : S_L2R;
      end
      S_L2R: begin
        l2_cmd.rd = 1'b1;
        state_next = S_L2;
      end
      S_L2: begin
        l2_cmd.upd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (take) begin
      i_cmd.rd = 1'b1;
      d_cmd.rd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
    if (take) begin
      cur <= req;
      l2_hit <= 1'b0;
      l2_looked <= 1'b0;
    end
    if (state == S_L1) l1_hit <= l1_on && l1h;
    if (state == S_L2) begin
      l2_looked <= 1'b1;
      l2_hit <= l2_sts.hit;
    end
  end

  logic [10:0] t;
  always_comb begin
    if (l1_hit) t = {3'd0, l1_time};
    else begin
      if (l2_looked) t = {3'd0, cfg.l2_hit_time} + (l2_hit ? 11'd0 : {1'b0, cfg.mem_latency});
      else t = {1'b0, cfg.mem_latency};
      if (l1_on) t = t + {3'd0, l1_time};
    end
  end

  assign done = state == S_OUT;
  assign rsp  = '{access_time: t, l1_hit: l1_hit, l2_looked_up: l2_looked, l2_hit: l2_hit};
endmodule

@@ rtl/two_level_lru_cache_timing.sv @@
`timescale 1ns / 1ps
// Tag-only timing model of split L1 instruction/data caches over a shared L2,
// true LRU everywhere. Issue a request with start while busy is low; the
// result appears on result with done high for exactly one cycle and cannot
// be stalled. An L1 hit (or disabled L2) goes from the L1 step to the
// result; an L1 miss that consults L2 adds an L2 read and an L2 update. Both
// L1 tag memories are read through their synchronous ports at accept and the
// addressed one is written if enabled; L2 is read and written only when
// consulted. Valid bits sit in the tag rows, so after reset every tag store
// is cleared one set per cycle; busy stays high until the largest (L2_SETS by
// default) is cleared. Write registers over APB only while busy is low.
module two_level_lru_cache_timing import tllc_pkg::*; #(
  parameter int I_SETS  = I_SETS_DEF,
  parameter int I_WAYS  = I_WAYS_DEF,
  parameter int D_SETS  = D_SETS_DEF,
  parameter int D_WAYS  = D_WAYS_DEF,
  parameter int L2_SETS = L2_SETS_DEF,
  parameter int L2_WAYS = L2_WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        request,
  output logic        busy,
  output logic        done,
  output rsp_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t cfg;
  logic [2:0] ridx;
  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{i_hit_time: 8'd1, d_hit_time: 8'd1, l2_hit_time: 8'd10,
               mem_latency: 10'd100, offset_bits: 4'd6,
               i_enable: 1'b1, d_enable: 1'b1, l2_enable: 1'b1};
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_I_HIT:  cfg.i_hit_time  <= pwdata[7:0];
        REG_D_HIT:  cfg.d_hit_time  <= pwdata[7:0];
        REG_L2_HIT: cfg.l2_hit_time <= pwdata[7:0];
        REG_MEM:    cfg.mem_latency <= pwdata[9:0];
        REG_OFFSET: cfg.offset_bits <= pwdata[3:0];
        REG_I_EN:   cfg.i_enable    <= pwdata[0];
        REG_D_EN:   cfg.d_enable    <= pwdata[0];
        REG_L2_EN:  cfg.l2_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_I_HIT:  prdata = {24'd0, cfg.i_hit_time};
      REG_D_HIT:  prdata = {24'd0, cfg.d_hit_time};
      REG_L2_HIT: prdata = {24'd0, cfg.l2_hit_time};
      REG_MEM:    prdata = {22'd0, cfg.mem_latency};
      REG_OFFSET: prdata = {28'd0, cfg.offset_bits};
      REG_I_EN:   prdata = {31'd0, cfg.i_enable};
      REG_D_EN:   prdata = {31'd0, cfg.d_enable};
      REG_L2_EN:  prdata = {31'd0, cfg.l2_enable};
      default:    prdata = '0;
    endcase
  end

  lvl_cmd_t i_cmd, d_cmd, l2_cmd;
  lvl_sts_t i_sts, d_sts, l2_sts;
  req_t     cur;
  logic [31:0] l1_addr;

  // L1 reads happen at accept, using the incoming address
  assign l1_addr = busy ? cur.addr : request.addr;

  tllc_ctrl u_ctrl (
    .clk, .rst, .start, .req(request), .cfg,
    .i_sts, .d_sts, .l2_sts, .i_cmd, .d_cmd, .l2_cmd,
    .busy, .cur, .done, .rsp(result)
  );

  tllc_level #(.SETS(I_SETS), .WAYS(I_WAYS)) u_il1 (
    .clk, .rst, .cmd(i_cmd), .addr(l1_addr), .offset_bits(cfg.offset_bits), .sts(i_sts)
  );

  tllc_level #(.SETS(D_SETS), .WAYS(D_WAYS)) u_dl1 (
    .clk, .rst, .cmd(d_cmd), .addr(l1_addr), .offset_bits(cfg.offset_bits), .sts(d_sts)
  );

  tllc_level #(.SETS(L2_SETS), .WAYS(L2_WAYS)) u_l2 (
    .clk, .rst, .cmd(l2_cmd), .addr(cur.addr), .offset_bits(cfg.offset_bits), .sts(l2_sts)
  );
endmodule

@@ rtl/tllc_checker.sv @@
`timescale 1ns / 1ps
module tllc_checker import tllc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done while idle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_no_dbl: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double result");
  a_hit_flags: assert property (@(posedge clk) disable iff (rst)
    done && result.l1_hit |-> !result.l2_looked_up && !result.l2_hit)
    else $error("L2 flags on L1 hit");
  a_l2_flags: assert property (@(posedge clk) disable iff (rst)
    done && result.l2_hit |-> result.l2_looked_up) else $error("L2 hit not looked up");
endmodule

bind two_level_lru_cache_timing tllc_checker u_chk (
  .clk, .rst, .start, .busy, .done, .result
);
